FILE: rtl/mvte_pkg.sv
// mvte_pkg: shared types, codes and sizes of the msi vector table engine
// no dependencies; used by the interfaces, the core and the checker

package mvte_pkg;

    // table depth and derived widths
    localparam int MAX_DEVICES = 32;
    localparam int IDX_W       = (MAX_DEVICES > 1) ? $clog2(MAX_DEVICES) : 1;
    localparam int CNT_W       = $clog2(MAX_DEVICES + 1);

    localparam int IRQ_W       = 20;
    localparam int SRC_W       = 21;
    localparam int ADDR_SHIFT  = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [IRQ_W-1:0] IRQ_FIRST_RESET = 20'h01000;
    localparam logic [IRQ_W-1:0] IRQ_LAST_RESET  = 20'hFFFFF;

    // operations
    localparam logic [1:0] OP_CHANGE    = 2'd0;
    localparam logic [1:0] OP_QUERY     = 2'd1;
    localparam logic [1:0] OP_MSI_WRITE = 2'd2;

    // change function codes
    localparam logic [3:0] FN_MSI     = 4'd1;
    localparam logic [3:0] FN_MSI_ALT = 4'd3;
    localparam logic [3:0] FN_MSIX    = 4'd4;

    // result status
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_HW    = 2'd1;
    localparam logic [1:0] ST_PARAM = 2'd2;

    // interrupt types
    localparam logic [1:0] IT_NONE = 2'd0;
    localparam logic [1:0] IT_MSI  = 2'd1;
    localparam logic [1:0] IT_MSIX = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_FIRST   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IRQ_LAST    = 2'd2;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] device_addr;
        logic [3:0]  function_code;
        logic [11:0] vector_request;
        logic [31:0] sequence_in;
        logic        device_present;
        logic [10:0] interrupt_offset;
        logic [20:0] window_offset;
        logic [13:0] message_data;
    } t_req;

    typedef struct packed {
        logic [1:0]       status;
        logic [11:0]      vector_count;
        logic [31:0]      sequence_out;
        logic [1:0]       interrupt_type;
        logic [63:0]      message_address;
        logic [4:0]       entry_index;
        logic [SRC_W-1:0] source_number;
        logic             edge_triggered;
    } t_rsp;

    typedef struct packed {
        logic [31:0]      key;
        logic [11:0]      vectors;
        logic [IRQ_W-1:0] irq_base;
    } t_entry;

endpackage

FILE: rtl/mvte_req_if.sv
// mvte_req_if: request channel, valid/ready with one request beat
// depends on mvte_pkg for the payload type

interface mvte_req_if;
    logic              valid;
    logic              ready;
    mvte_pkg::t_req    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/mvte_rsp_if.sv
// mvte_rsp_if: result channel, valid/ready with one result beat
// depends on mvte_pkg for the payload type

interface mvte_rsp_if;
    logic              valid;
    logic              ready;
    mvte_pkg::t_rsp    data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/msi_vector_table_engine_core.sv
// msi_vector_table_engine_core: device to interrupt block table of a host bridge
// depends on mvte_pkg, mvte_req_if and mvte_rsp_if
//
// usage
// - i_req carries one request beat: change (find or allocate an entry and
//   give it a block of interrupt numbers), query (base of an entry plus an
//   offset) or msi window write (entry and vector decoded into an irq)
// - o_rsp carries exactly one result beat per request, in request order
// - i_cfg_we / i_cfg_idx / i_cfg_data write the window base, first irq and
//   last irq; writing the first irq also reloads the bump allocator
// - change and query walk the table one entry per cycle through the
//   registered read port
// - one request is in flight at a time; the next is taken once the result
//   sits in the output register, even if the receiver has not taken it
// - reset empties the table at once (entries below the fill count are the
//   only live ones) and restores the register defaults
// - a stalled receiver holds the output beat; the engine finishes the next
//   request and then waits for the output register to drain

module msi_vector_table_engine_core (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    mvte_req_if.sink                              i_req,
    mvte_rsp_if.source                            o_rsp,
    input  logic                                  i_cfg_we,
    input  logic [mvte_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [mvte_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_MSI,
        S_DONE
    } t_state;

    t_state r_state;

    // configuration
    logic [63:0]                    r_win_base;
    logic [mvte_pkg::IRQ_W-1:0]     r_irq_last;
    logic [mvte_pkg::IRQ_W-1:0]     r_next_free;

    // table: entries below r_fill are live, the rest read as empty
    mvte_pkg::t_entry               mem [mvte_pkg::MAX_DEVICES];
    mvte_pkg::t_entry               r_q;
    logic [mvte_pkg::CNT_W-1:0]     r_fill;

    // request being worked
    mvte_pkg::t_req                 r_req;
    logic [1:0]                     r_type;
    logic                           r_msi_in_range;
    logic                           r_msi_live;

    // scan pipeline: read issued one cycle, compared the next
    logic [mvte_pkg::CNT_W-1:0]     r_rd_idx;
    logic                           r_pend;
    logic [mvte_pkg::IDX_W-1:0]     r_pend_idx;

    // result staging and output register
    mvte_pkg::t_rsp                 r_res;
    mvte_pkg::t_rsp                 r_out;
    logic                           r_out_valid;

    // combinational
    logic                           acc;
    logic                           out_load;
    logic [4:0]                     in_ent;
    logic [1:0]                     in_type;
    logic                           in_param_err;
    logic [mvte_pkg::IDX_W-1:0]     rd_addr;
    logic                           scan_hit;
    logic                           scan_end;
    logic                           fill_full;
    logic [mvte_pkg::SRC_W-1:0]     alloc_top;
    logic                           alloc_over;
    logic                           alloc_ok;
    logic                           mem_we;
    logic [mvte_pkg::IDX_W-1:0]     succ_idx;
    mvte_pkg::t_entry               new_entry;
    mvte_pkg::t_rsp                 accept_res;
    mvte_pkg::t_rsp                 scan_res;
    mvte_pkg::t_rsp                 msi_res;
    logic [13:0]                    msi_vec;
    logic [mvte_pkg::IRQ_W-1:0]     msi_base;

    assign acc         = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;

    // staged result moves into the output register once that is free
    assign out_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    assign in_ent = i_req.data.window_offset[20:16];

    // decode function code into interrupt type
    always_comb begin
        in_type = mvte_pkg::IT_NONE;
        unique case (i_req.data.function_code)
            mvte_pkg::FN_MSI,
            mvte_pkg::FN_MSI_ALT: in_type = mvte_pkg::IT_MSI;
            mvte_pkg::FN_MSIX:    in_type = mvte_pkg::IT_MSIX;
            default:              in_type = mvte_pkg::IT_NONE;
        endcase
    end

    // requests answered without touching the table
    always_comb begin
        in_param_err = 1'b0;
        if (i_req.data.operation == mvte_pkg::OP_CHANGE) begin
            in_param_err = (in_type == mvte_pkg::IT_NONE) || !i_req.data.device_present;
        end else if (i_req.data.operation != mvte_pkg::OP_QUERY &&
                     i_req.data.operation != mvte_pkg::OP_MSI_WRITE) begin
            in_param_err = 1'b1;
        end
        accept_res        = '0;
        accept_res.status = mvte_pkg::ST_PARAM;
    end

    // one read port: msi entry while idle, scan pointer while scanning
    assign rd_addr = (r_state == S_IDLE) ? mvte_pkg::IDX_W'(in_ent)
                                         : r_rd_idx[mvte_pkg::IDX_W-1:0];

    // scan compare on the data read last cycle
    assign scan_hit  = r_pend && (r_q.key == r_req.device_addr);
    assign scan_end  = (r_rd_idx == r_fill);
    assign fill_full = (r_fill == mvte_pkg::CNT_W'(mvte_pkg::MAX_DEVICES));

    // bump allocator bound, no wrap: base + request - 1 against last irq
    assign alloc_top  = {1'b0, r_next_free} + mvte_pkg::SRC_W'(r_req.vector_request)
                        - mvte_pkg::SRC_W'(1);
    assign alloc_over = alloc_top > {1'b0, r_irq_last};
    assign alloc_ok   = (r_req.operation == mvte_pkg::OP_CHANGE) &&
                        (r_req.vector_request != 12'd0) && !fill_full && !alloc_over;
    assign mem_we     = (r_state == S_SCAN) && !scan_hit && scan_end && alloc_ok;
    assign succ_idx   = scan_hit ? r_pend_idx : r_fill[mvte_pkg::IDX_W-1:0];

    assign new_entry.key      = r_req.device_addr;
    assign new_entry.vectors  = r_req.vector_request;
    assign new_entry.irq_base = r_next_free;

    // result of a change or query once the scan has settled
    always_comb begin
        scan_res = '0;
        if (r_req.operation == mvte_pkg::OP_QUERY) begin
            if (scan_hit) begin
                scan_res.status         = mvte_pkg::ST_OK;
                scan_res.entry_index    = 5'(r_pend_idx);
                scan_res.source_number  = mvte_pkg::SRC_W'(r_q.irq_base)
                                          + mvte_pkg::SRC_W'(r_req.interrupt_offset);
                scan_res.edge_triggered = 1'b1;
            end else begin
                scan_res.status = mvte_pkg::ST_HW;
            end
        end else if (r_req.vector_request == 12'd0) begin
            // zero request only checks that the device has an entry
            if (scan_hit) begin
                scan_res.status      = mvte_pkg::ST_OK;
                scan_res.entry_index = 5'(r_pend_idx);
            end else begin
                scan_res.status = mvte_pkg::ST_HW;
            end
        end else if ((scan_hit && r_q.vectors != r_req.vector_request) ||
                     (!scan_hit && !alloc_ok)) begin
            scan_res.status = mvte_pkg::ST_HW;
        end else begin
            scan_res.status          = mvte_pkg::ST_OK;
            scan_res.vector_count    = r_req.vector_request;
            scan_res.sequence_out    = r_req.sequence_in + 32'd1;
            scan_res.interrupt_type  = r_type;
            scan_res.message_address = r_win_base |
                                       (64'(succ_idx) << mvte_pkg::ADDR_SHIFT);
            scan_res.entry_index     = 5'(succ_idx);
        end
    end

    // msi window write: entry base plus decoded vector
    assign msi_vec  = r_req.window_offset[15:2] | r_req.message_data;
    assign msi_base = r_msi_live ? r_q.irq_base : '0;

    always_comb begin
        msi_res             = '0;
        msi_res.entry_index = r_req.window_offset[20:16];
        if (r_msi_in_range) begin
            msi_res.status        = mvte_pkg::ST_OK;
            msi_res.source_number = mvte_pkg::SRC_W'(msi_base) + mvte_pkg::SRC_W'(msi_vec);
        end else begin
            msi_res.status = mvte_pkg::ST_HW;
        end
    end

    // table memory, one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_fill[mvte_pkg::IDX_W-1:0]] <= new_entry;
        end
        r_q <= mem[rd_addr];
    end

    // control, configuration and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_fill      <= '0;
            r_pend      <= 1'b0;
            r_rd_idx    <= '0;
            r_win_base  <= '0;
            r_irq_last  <= mvte_pkg::IRQ_LAST_RESET;
            r_next_free <= mvte_pkg::IRQ_FIRST_RESET;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.valid && o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    mvte_pkg::CFG_WINDOW_BASE: r_win_base  <= i_cfg_data;
                    mvte_pkg::CFG_IRQ_FIRST:   r_next_free <= i_cfg_data[mvte_pkg::IRQ_W-1:0];
                    mvte_pkg::CFG_IRQ_LAST:    r_irq_last  <= i_cfg_data[mvte_pkg::IRQ_W-1:0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (acc) begin
                        r_req  <= i_req.data;
                        r_type <= in_type;
                        if (in_param_err) begin
                            r_res   <= accept_res;
                            r_state <= S_DONE;
                        end else if (i_req.data.operation == mvte_pkg::OP_MSI_WRITE) begin
                            r_msi_in_range <= 32'(in_ent) < 32'(mvte_pkg::MAX_DEVICES);
                            r_msi_live     <= 32'(in_ent) < 32'(r_fill);
                            r_state        <= S_MSI;
                        end else begin
                            r_rd_idx <= '0;
                            r_pend   <= 1'b0;
                            r_state  <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_hit || scan_end) begin
                        r_res <= scan_res;
                        if (mem_we) begin
                            r_fill      <= r_fill + mvte_pkg::CNT_W'(1);
                            r_next_free <= r_next_free
                                           + mvte_pkg::IRQ_W'(r_req.vector_request);
                        end
                        r_pend  <= 1'b0;
                        r_state <= S_DONE;
                    end else begin
                        r_pend     <= 1'b1;
                        r_pend_idx <= r_rd_idx[mvte_pkg::IDX_W-1:0];
                        r_rd_idx   <= r_rd_idx + mvte_pkg::CNT_W'(1);
                    end
                end
                S_MSI: begin
                    r_res   <= msi_res;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    // hand over once the output register is free
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

FILE: rtl/mvte_checker.sv
// mvte_core_props: port-level assertions for msi_vector_table_engine_core
// depends on mvte_pkg; bound to the core at the end of this file

module mvte_core_props (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             i_req_valid,
    input logic             i_req_ready,
    input logic             i_rsp_valid,
    input logic             i_rsp_ready,
    input mvte_pkg::t_rsp   i_rsp_data
);

    // a held result beat keeps its payload
    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && !i_rsp_ready |=> i_rsp_valid && $stable(i_rsp_data))
        else $error("result beat changed while stalled");

    // no result beat right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_rsp_valid)
        else $error("result beat after reset");

    // one request at a time: busy after an accepted beat
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |=> !i_req_ready)
        else $error("request taken while busy");

    // failed results carry only status and entry
    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.status != mvte_pkg::ST_OK |->
            i_rsp_data.vector_count == '0 && i_rsp_data.sequence_out == '0 &&
            i_rsp_data.interrupt_type == mvte_pkg::IT_NONE &&
            i_rsp_data.message_address == '0 && i_rsp_data.source_number == '0 &&
            !i_rsp_data.edge_triggered)
        else $error("failed result carries data");

    // edge flag only on a successful query
    a_edge_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid && i_rsp_data.edge_triggered |->
            i_rsp_data.status == mvte_pkg::ST_OK &&
            i_rsp_data.interrupt_type == mvte_pkg::IT_NONE &&
            i_rsp_data.vector_count == '0)
        else $error("edge flag outside a query result");

endmodule

bind msi_vector_table_engine_core mvte_core_props u_mvte_core_props (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req.valid),
    .i_req_ready (i_req.ready),
    .i_rsp_valid (o_rsp.valid),
    .i_rsp_ready (o_rsp.ready),
    .i_rsp_data  (o_rsp.data)
);

FILE: test/mvte_checker.sv
// mvte_checker: watches the request, result and register-write ports of the msi vector
// table engine, predicts every result beat and compares it field by field
// depends on mvte_pkg, mvte_req_if and mvte_rsp_if

module mvte_checker
    import mvte_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    mvte_req_if                   req_mon,
    mvte_rsp_if                   rsp_mon,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_pending,
    output int                    o_failures
);
    timeunit 1ns;
    timeprecision 1ps;

    // shadow of the device table and allocator
    logic [31:0]      slot_key     [MAX_DEVICES];
    logic [11:0]      slot_vectors [MAX_DEVICES];
    logic [IRQ_W-1:0] slot_base    [MAX_DEVICES];
    logic [IRQ_W-1:0] next_irq;
    logic [63:0]      window_base;
    logic [IRQ_W-1:0] first_irq;
    logic [IRQ_W-1:0] last_irq;

    t_rsp awaited_results[$];
    int   mismatches = 0;

    function automatic void clear_table();
        for (int i = 0; i < MAX_DEVICES; i++) begin
            slot_key[i]     = '0;
            slot_vectors[i] = '0;
            slot_base[i]    = '0;
        end
        window_base = '0;
        first_irq   = IRQ_FIRST_RESET;
        last_irq    = IRQ_LAST_RESET;
        next_irq    = IRQ_FIRST_RESET;
    endfunction

    // scan stops at the first empty slot, which is also the one to allocate
    function automatic int find_slot(input logic [31:0] key, input bit allocate);
        int i;
        for (i = 0; i < MAX_DEVICES; i++) begin
            if (slot_vectors[i] == '0) break;
            if (slot_key[i] == key) return i;
        end
        if (i < MAX_DEVICES && allocate) return i;
        return -1;
    endfunction

    function automatic t_rsp resolve_request(input t_req r);
        t_rsp             res;
        logic [1:0]       itype;
        int               slot;
        logic [31:0]      top_irq;
        logic [4:0]       ent;
        logic [13:0]      vec;
        res = '0;
        case (r.operation)
            OP_CHANGE: begin
                if (r.function_code == FN_MSI || r.function_code == FN_MSI_ALT) begin
                    itype = IT_MSI;
                end else if (r.function_code == FN_MSIX) begin
                    itype = IT_MSIX;
                end else begin
                    res.status = ST_PARAM;
                    return res;
                end
                if (!r.device_present) begin
                    res.status = ST_PARAM;
                    return res;
                end
                if (r.vector_request == '0) begin
                    slot = find_slot(r.device_addr, 1'b0);
                    if (slot < 0) begin
                        res.status = ST_HW;
                    end else begin
                        res.status      = ST_OK;
                        res.entry_index = 5'(slot);
                    end
                    return res;
                end
                slot = find_slot(r.device_addr, 1'b1);
                if (slot < 0) begin
                    res.status = ST_HW;
                    return res;
                end
                if (slot_vectors[slot] != '0 && slot_vectors[slot] != r.vector_request) begin
                    res.status = ST_HW;
                    return res;
                end
                if (slot_vectors[slot] == '0) begin
                    // allocator bound is checked without wrap
                    top_irq = 32'(next_irq) + 32'(r.vector_request) - 32'd1;
                    if (top_irq > 32'(last_irq)) begin
                        res.status = ST_HW;
                        return res;
                    end
                    slot_base[slot]    = next_irq;
                    slot_vectors[slot] = r.vector_request;
                    slot_key[slot]     = r.device_addr;
                    next_irq           = IRQ_W'(top_irq + 32'd1);
                end
                res.status          = ST_OK;
                res.vector_count    = r.vector_request;
                res.sequence_out    = r.sequence_in + 32'd1;
                res.interrupt_type  = itype;
                res.message_address = window_base | (64'(slot) << ADDR_SHIFT);
                res.entry_index     = 5'(slot);
            end
            OP_QUERY: begin
                slot = find_slot(r.device_addr, 1'b0);
                if (slot < 0) begin
                    res.status = ST_HW;
                end else begin
                    res.status         = ST_OK;
                    res.entry_index    = 5'(slot);
                    res.source_number  = SRC_W'(slot_base[slot]) + SRC_W'(r.interrupt_offset);
                    res.edge_triggered = 1'b1;
                end
            end
            OP_MSI_WRITE: begin
                ent = r.window_offset[20:16];
                vec = r.window_offset[15:2] | r.message_data;
                res.entry_index = ent;
                if (int'(ent) >= MAX_DEVICES) begin
                    res.status = ST_HW;
                end else begin
                    res.status        = ST_OK;
                    res.source_number = SRC_W'(slot_base[ent]) + SRC_W'(vec);
                end
            end
            default: res.status = ST_PARAM;
        endcase
        return res;
    endfunction

    task automatic compare_field(input string field, input logic [63:0] want,
                                 input logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            mismatches++;
        end
    endtask

    task automatic check_result(input t_rsp got);
        t_rsp want;
        if (awaited_results.size() == 0) begin
            $display("%0t: result beat with nothing expected, expected none, got %h",
                     $time, got);
            mismatches++;
            return;
        end
        want = awaited_results.pop_front();
        compare_field("status", want.status, got.status);
        compare_field("vector_count", want.vector_count, got.vector_count);
        compare_field("sequence_out", want.sequence_out, got.sequence_out);
        compare_field("interrupt_type", want.interrupt_type, got.interrupt_type);
        compare_field("message_address", want.message_address, got.message_address);
        compare_field("entry_index", want.entry_index, got.entry_index);
        compare_field("source_number", want.source_number, got.source_number);
        compare_field("edge_triggered", want.edge_triggered, got.edge_triggered);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_table();
            awaited_results.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_WINDOW_BASE: window_base = i_cfg_data;
                    CFG_IRQ_FIRST: begin
                        first_irq = i_cfg_data[IRQ_W-1:0];
                        next_irq  = i_cfg_data[IRQ_W-1:0];
                    end
                    CFG_IRQ_LAST: last_irq = i_cfg_data[IRQ_W-1:0];
                    default: ;
                endcase
            end
            if (req_mon.valid && req_mon.ready)
                awaited_results.push_back(resolve_request(req_mon.data));
            if (rsp_mon.valid && rsp_mon.ready)
                check_result(rsp_mon.data);
        end
        o_pending  <= awaited_results.size();
        o_failures <= mismatches;
    end

endmodule

FILE: test/testbench.sv
// testbench: drives the msi vector table engine with directed and random request beats
// under several idle/stall mixes and register settings; mvte_checker predicts and checks
// depends on mvte_pkg, mvte_req_if, mvte_rsp_if, mvte_checker and the core

module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mvte_pkg::*;

    // codes with no name in the package: unused operation and bad function codes
    localparam logic [1:0] OP_UNUSED     = 2'd3;
    localparam logic [3:0] FN_INVALID_LO = 4'd0;
    localparam logic [3:0] FN_INVALID_HI = 4'd15;

    localparam int POOL_SIZE       = 40;   // more keys than table slots, so it fills
    localparam int ITEMS_PER_PHASE = 300;
    localparam int SETTLE_CYCLES   = 40;
    localparam int IDLE_LIMIT      = 2000;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    pending;
    int                    failures;
    int                    src_idle   = 0;   // percent of cycles the sender sits out
    int                    sink_stall = 0;   // percent of cycles the receiver stalls
    int                    quiet_cycles = 0;

    // device keys the random part reuses, each with its usual vector count
    logic [31:0] key_pool  [POOL_SIZE];
    logic [11:0] key_count [POOL_SIZE];
    int          live_keys = 4;

    mvte_req_if req_bus ();
    mvte_rsp_if rsp_bus ();

    msi_vector_table_engine_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_bus),
        .o_rsp      (rsp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    mvte_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .req_mon    (req_bus),
        .rsp_mon    (rsp_bus),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .o_pending  (pending),
        .o_failures (failures)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // receiver side: ready toggles at random according to the current stall mix
    initial begin
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_bus.ready <= ($urandom_range(0, 99) >= sink_stall);
        end
    end

    // watchdog: too long without any beat moving on either channel
    always @(posedge i_clk) begin
        if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one request beat; valid stays high on return so a back-to-back beat
    // does not lower and raise it in one step
    task automatic push(input t_req r);
        while ($urandom_range(0, 99) < src_idle) begin
            req_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_bus.valid <= 1'b1;
        req_bus.data  <= r;
        do @(posedge i_clk); while (!req_bus.ready);
    endtask

    // stop sending until every predicted result has come back, then hold a while
    // (first edge lets the checker count the last accepted beat)
    task automatic drain(input int hold);
        req_bus.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (hold) @(posedge i_clk);
    endtask

    // write all three registers back to back; only while the engine is idle
    task automatic program_regs(input logic [63:0] base, input logic [IRQ_W-1:0] first,
                                input logic [IRQ_W-1:0] last);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_WINDOW_BASE;
        cfg_data <= base;
        @(posedge i_clk);
        cfg_idx  <= CFG_IRQ_FIRST;
        cfg_data <= CFG_DATA_W'(first);
        @(posedge i_clk);
        cfg_idx  <= CFG_IRQ_LAST;
        cfg_data <= CFG_DATA_W'(last);
        @(posedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    function automatic t_req directed_request(input logic [1:0] op, input logic [31:0] key,
                                              input logic [3:0] fn, input logic [11:0] count,
                                              input logic present, input logic [10:0] ioff,
                                              input logic [20:0] woff,
                                              input logic [13:0] mdata);
        t_req r;
        r.operation        = op;
        r.device_addr      = key;
        r.function_code    = fn;
        r.vector_request   = count;
        r.sequence_in      = $urandom();
        r.device_present   = present;
        r.interrupt_offset = ioff;
        r.window_offset    = woff;
        r.message_data     = mdata;
        return r;
    endfunction

    // random beat: every field fully random first, then mostly shaped into well-formed
    // change/query traffic on known keys so the table fills and the count checks bite
    function automatic t_req random_request();
        t_req r;
        int   roll;
        int   pick;
        bit   known;
        r.operation        = 2'($urandom_range(0, 3));
        r.device_addr      = $urandom();
        r.function_code    = 4'($urandom_range(0, 15));
        r.vector_request   = 12'($urandom_range(0, 4095));
        r.sequence_in      = $urandom();
        r.device_present   = 1'($urandom_range(0, 1));
        r.interrupt_offset = 11'($urandom_range(0, 2047));
        r.window_offset    = 21'($urandom_range(0, 2097151));
        r.message_data     = 14'($urandom_range(0, 16383));

        roll = $urandom_range(0, 99);
        if (roll < 55)      r.operation = OP_CHANGE;
        else if (roll < 80) r.operation = OP_QUERY;
        else if (roll < 96) r.operation = OP_MSI_WRITE;

        known = ($urandom_range(0, 99) < 85);
        pick  = $urandom_range(0, live_keys - 1);
        if (known) r.device_addr = key_pool[pick];

        if (r.operation == OP_CHANGE) begin
            if ($urandom_range(0, 99) < 85) begin
                case ($urandom_range(0, 2))
                    0:       r.function_code = FN_MSI;
                    1:       r.function_code = FN_MSI_ALT;
                    default: r.function_code = FN_MSIX;
                endcase
            end
            r.device_present = ($urandom_range(0, 99) < 93);
            roll = $urandom_range(0, 99);
            if (known && roll < 80)      r.vector_request = key_count[pick];
            else if (roll < 87)          r.vector_request = '0;
            else if (roll < 95)          r.vector_request = 12'($urandom_range(1, 64));
        end
        return r;
    endfunction

    initial begin
        t_req item;
        int   item_no;

        req_bus.valid <= 1'b0;
        req_bus.data  <= '0;
        cfg_we        <= 1'b0;
        cfg_idx       <= '0;
        cfg_data      <= '0;
        i_rst_n       <= 1'b0;

        // key 0 and all-ones are in the pool; key 0 keeps the count the directed part uses
        for (int i = 0; i < POOL_SIZE; i++) begin
            key_pool[i] = $urandom();
            case ($urandom_range(0, 9))
                0:       key_count[i] = 12'($urandom_range(2049, 4095));
                1, 2:    key_count[i] = 12'($urandom_range(17, 2048));
                default: key_count[i] = 12'($urandom_range(1, 16));
            endcase
        end
        key_pool[0]  = '0;
        key_count[0] = 12'hFFF;
        key_pool[1]  = '1;
        key_count[1] = 12'd1;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---------------- directed part ----------------
        program_regs(64'h0000_0000_FEE0_0000, IRQ_FIRST_RESET, IRQ_LAST_RESET);

        // first allocations: msi with one vector, msi-x with the largest nominal count
        push(directed_request(OP_CHANGE, 32'h0000_0800, FN_MSI, 12'd1, 1'b1, '0, '0, '0));
        push(directed_request(OP_CHANGE, 32'h0012_3400, FN_MSIX, 12'd2048, 1'b1, '0, '0,
                              '0));
        // same key, same count: found again; then a changed count is refused
        push(directed_request(OP_CHANGE, 32'h0000_0800, FN_MSI_ALT, 12'd1, 1'b1, '0, '0,
                              '0));
        push(directed_request(OP_CHANGE, 32'h0000_0800, FN_MSI, 12'd7, 1'b1, '0, '0, '0));
        // parameter errors: bad function codes at both ends, missing device
        push(directed_request(OP_CHANGE, 32'h0000_5600, FN_INVALID_LO, 12'd1, 1'b1, '0, '0,
                              '0));
        push(directed_request(OP_CHANGE, 32'h0000_5600, FN_INVALID_HI, 12'd1, 1'b1, '0, '0,
                              '0));
        push(directed_request(OP_CHANGE, 32'h0000_5600, FN_MSI, 12'd1, 1'b0, '0, '0, '0));
        // zero request only checks for an entry
        push(directed_request(OP_CHANGE, 32'h0000_0800, FN_MSI, 12'd0, 1'b1, '0, '0, '0));
        push(directed_request(OP_CHANGE, 32'h0000_5600, FN_MSIX, 12'd0, 1'b1, '0, '0, '0));
        // queries: largest offset, zero offset, unknown key
        push(directed_request(OP_QUERY, 32'h0012_3400, FN_MSI, '0, 1'b1, 11'h7FF, '0, '0));
        push(directed_request(OP_QUERY, 32'h0000_0800, FN_MSI, '0, 1'b1, '0, '0, '0));
        push(directed_request(OP_QUERY, 32'h0000_5600, FN_MSI, '0, 1'b1, '0, '0, '0));
        // msi window writes: live entry, all-ones offset and data (empty entry), all zero
        push(directed_request(OP_MSI_WRITE, '0, FN_MSI, '0, 1'b1, '0, 21'h01_0000, '0));
        push(directed_request(OP_MSI_WRITE, '0, FN_MSI, '0, 1'b1, '0, '1, '1));
        push(directed_request(OP_MSI_WRITE, '0, FN_MSI, '0, 1'b1, '0, '0, '0));
        push(directed_request(OP_UNUSED, '0, FN_MSI, '0, 1'b1, '0, '0, '0));
        // largest field count, with the sequence number wrapping to zero
        item = directed_request(OP_CHANGE, '0, FN_MSIX, 12'hFFF, 1'b1, '0, '0, '0);
        item.sequence_in = '1;
        push(item);
        push(directed_request(OP_CHANGE, '1, FN_MSI, 12'd1, 1'b1, '0, '0, '0));
        push(directed_request(OP_QUERY, '0, FN_MSI, '0, 1'b1, 11'h7FF, '0, '0));

        // allocator right at the top of the irq space: overflow refused, then a wrap to 0
        drain(SETTLE_CYCLES);
        program_regs('1, 20'hFFFFE, 20'hFFFFF);
        push(directed_request(OP_CHANGE, 32'h00AB_0000, FN_MSI, 12'd3, 1'b1, '0, '0, '0));
        push(directed_request(OP_CHANGE, 32'h00AB_0000, FN_MSI, 12'd2, 1'b1, '0, '0, '0));
        push(directed_request(OP_CHANGE, 32'h00CD_0000, FN_MSIX, 12'd1, 1'b1, '0, '0, '0));
        push(directed_request(OP_MSI_WRITE, '0, FN_MSI, '0, 1'b1, '0, 21'h05_0004, 14'd1));
        push(directed_request(OP_QUERY, 32'h00CD_0000, FN_MSI, '0, 1'b1, 11'd3, '0, '0));

        // ---------------- random phases ----------------
        item_no = 0;
        for (int phase = 0; phase < 4; phase++) begin
            drain(SETTLE_CYCLES);
            case (phase)
                0: begin
                    // no idling, default allocator range
                    program_regs({$urandom(), $urandom()}, IRQ_FIRST_RESET, IRQ_LAST_RESET);
                    src_idle   = 0;
                    sink_stall = 0;
                end
                1: begin
                    // bottom of the irq space with a tight limit: allocations run dry
                    program_regs('0, '0, 20'd600);
                    src_idle   = 50;
                    sink_stall = 0;
                end
                2: begin
                    // near the top: next free irq wraps past the last one
                    program_regs('1, 20'hFFF00, 20'hFFFFF);
                    src_idle   = 0;
                    sink_stall = 50;
                end
                default: begin
                    program_regs({$urandom(), $urandom()}, IRQ_W'($urandom()),
                                 IRQ_W'($urandom()));
                    src_idle   = 12;
                    sink_stall = 12;
                end
            endcase

            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                push(random_request());
                item_no++;
                // more keys come into play over time so the table fills gradually
                if (item_no % 30 == 0 && live_keys < POOL_SIZE) live_keys++;
                // now and then let the pipe run completely empty
                if ($urandom_range(0, 199) == 0) drain(0);
            end
        end

        drain(SETTLE_CYCLES);
        if (failures == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

FILE: filelist.f
rtl/mvte_pkg.sv
rtl/mvte_req_if.sv
rtl/mvte_rsp_if.sv
rtl/msi_vector_table_engine_core.sv
rtl/mvte_checker.sv
test/mvte_checker.sv
test/testbench.sv
